// ===== src/periodic_frame_tx_scheduler_assert.svh =====
// Assertion macros for the periodic frame transmit scheduler.
`ifndef PERIODIC_FRAME_TX_SCHEDULER_ASSERT_SVH
`define PERIODIC_FRAME_TX_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PFTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfts assertion failed");

// next-cycle implication
`define PFTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfts assertion failed");

`endif

// ===== src/pfts_pkg.sv =====
// Types, codes and helpers shared by the frame scheduler modules.
`default_nettype none
package pfts_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOT_W        = 4;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_KEY  = 2'd2;
   localparam logic [1:0] ACT_BUS  = 2'd3;

   localparam logic [1:0] BUS_DISC = 2'd0;
   localparam logic [1:0] BUS_PRE  = 2'd1;
   localparam logic [1:0] BUS_CONN = 2'd2;

   localparam logic [3:0] MAX_LEN = 4'd8;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [15:0] period;
      logic        timer_enable;
      logic        key_enable;
      logic [7:0]  key_code;
      logic [3:0]  channel;
      logic [5:0]  frame_id;
      logic [3:0]  data_length;
      logic [63:0] payload;
      logic [1:0]  bus_status;
   } req_type;

   typedef struct packed {
      logic [3:0]  sent_slot;
      logic [3:0]  sent_channel;
      logic [5:0]  sent_frame_id;
      logic [3:0]  sent_length;
      logic [63:0] sent_payload;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [15:0] period;
      logic [15:0] countdown;
      logic        timer_on;
      logic        key_on;
      logic [7:0]  key_code;
      logic [3:0]  channel;
      logic [5:0]  frame_id;
      logic [3:0]  length;
      logic [63:0] payload;
   } entry_type;

   typedef struct packed {
      logic              shift;
      logic              load;
      logic [SLOT_W-1:0] load_slot;
   } ring_ctrl_type;

   // zero the bytes at or above len (len already clamped to 8)
   function automatic logic [63:0] mask_payload(input logic [3:0] len,
                                                input logic [63:0] data);
      logic [63:0] res;
      res = '0;
      for (int b = 0; b < 8; b++) begin
         if (32'(len) > b) begin
            res[b*8 +: 8] = data[b*8 +: 8];
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/pfts_cell.sv =====
// One table entry of the rotating entry ring.
`default_nettype none
module pfts_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift,
   input  wire logic               load,
   input  wire pfts_pkg::entry_type load_entry,
   input  wire pfts_pkg::entry_type prev_entry,
   output pfts_pkg::entry_type      entry
);
   import pfts_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.timer_on <= 1'b0;
         entry_ff.key_on   <= 1'b0;
      end else if (load) begin
         entry_ff <= load_entry;
      end else if (shift) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// ===== src/pfts_seq.sv =====
// Scan sequencer: takes words, walks the ring, queues and sends frames.
`default_nettype none
module pfts_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pfts_pkg::req_type      req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pfts_pkg::rsp_type           rsp_word,
   input  wire logic                  csr_we,
   input  wire logic [4:0]            csr_wdata,
   input  wire pfts_pkg::entry_type    head_entry,
   output pfts_pkg::entry_type         load_entry,
   output pfts_pkg::entry_type         tail_entry,
   output pfts_pkg::ring_ctrl_type     ring_ctrl
);
   import pfts_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       bus_ff, bus_in;
   logic [1:0]       mode_ff, mode_in;
   logic [7:0]       key_ff, key_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic    accept;
   logic    in_use;
   logic    hit;
   logic    emit;
   logic    out_free;
   logic    stall;
   logic    last_step;
   rsp_type head_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_use    = (step_ff < count_ff);
   assign last_step = (step_ff == CNT_W'(TABLE_ENTRIES - 1));

   always_comb begin
      case (mode_ff)
         ACT_TICK: hit = head_entry.timer_on && (head_entry.countdown <= 16'd1);
         ACT_KEY:  hit = head_entry.key_on && (head_entry.key_code == key_ff);
         ACT_BUS:  hit = 1'b1;
         default:  hit = 1'b0;
      endcase
   end

   assign emit  = (state_ff == ST_SCAN) && in_use && hit;
   assign stall = emit && pend_valid_ff && !out_free;

   always_comb begin
      head_rsp.sent_slot     = SLOT_W'(step_ff);
      head_rsp.sent_channel  = head_entry.channel;
      head_rsp.sent_frame_id = head_entry.frame_id;
      head_rsp.sent_length   = head_entry.length;
      head_rsp.sent_payload  = mask_payload(head_entry.length, head_entry.payload);
      head_rsp.last_of_run   = 1'b0;
   end

   // load word into entry form
   always_comb begin
      load_entry.period    = req_word.period;
      load_entry.countdown = req_word.period;
      load_entry.timer_on  = req_word.timer_enable;
      load_entry.key_on    = req_word.key_enable;
      load_entry.key_code  = req_word.key_code;
      load_entry.channel   = req_word.channel;
      load_entry.frame_id  = req_word.frame_id;
      load_entry.length    = (req_word.data_length > MAX_LEN) ? MAX_LEN
                                                               : req_word.data_length;
      load_entry.payload   = req_word.payload;
   end

   // head goes back in at the tail, countdown stepped on a tick
   always_comb begin
      tail_entry = head_entry;
      if (mode_ff == ACT_TICK && in_use && head_entry.timer_on) begin
         if (head_entry.countdown <= 16'd1) begin
            tail_entry.countdown = head_entry.period;
         end else begin
            tail_entry.countdown = head_entry.countdown - 16'd1;
         end
      end
   end

   always_comb begin
      ring_ctrl.shift     = (state_ff == ST_SCAN) && !stall;
      ring_ctrl.load      = accept && (req_word.action == ACT_LOAD) &&
                            (32'(req_word.slot) < TABLE_ENTRIES);
      ring_ctrl.load_slot = req_word.slot;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      bus_in        = bus_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_we) begin
         count_in = (32'(csr_wdata) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                     : CNT_W'(csr_wdata);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = '0;
               mode_in = req_word.action;
               key_in  = req_word.key_code;
               case (req_word.action)
                  ACT_TICK, ACT_KEY: begin
                     if (bus_ff == BUS_CONN) begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_BUS: begin
                     bus_in = req_word.bus_status;
                     if (req_word.bus_status == BUS_PRE) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (emit) begin
                  pend_valid_in = 1'b1;
                  pend_in       = head_rsp;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
               end
               step_in = step_ff + CNT_W'(1);
               if (last_step) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = pend_ff;
               rsp_in.last_of_run   = 1'b1;
               pend_valid_in        = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         bus_ff        <= BUS_DISC;
         mode_ff       <= ACT_LOAD;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         bus_ff        <= bus_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff  <= key_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

// ===== src/periodic_frame_tx_scheduler.sv =====
// Top level of the periodic frame transmit scheduler: entry ring plus sequencer.
// Sequence: a load, an ignored tick or key, or a non-preconnect bus word runs no scan;
//   tick, key and preconnect words scan all TABLE_ENTRIES cells and then pass the flush state.
//   A found frame leaves at the edge that finds the next one; the last leaves from the flush state.
// Words: a new word is taken only while idle, after the scan and flush; the ring rotates one
//   entry per cycle unless a found frame waits on rsp back-pressure, which holds the ring.
// Reset: enables cleared, bus disconnected, entries_in_use zero; no clearing pass.
`default_nettype none
`include "periodic_frame_tx_scheduler_assert.svh"
module periodic_frame_tx_scheduler (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pfts_pkg::req_type   req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pfts_pkg::rsp_type        rsp_word,
   input  wire logic               csr_we,
   input  wire logic [4:0]         csr_wdata
);
   import pfts_pkg::*;

   // The table lives in a ring of cells. Cell 0 is the head that the
   // sequencer inspects; in every unstalled scan cycle each cell takes the entry of its
   // upper neighbor and the top cell takes the (possibly updated) head.
   // A scan always rotates the full ring, so between words slot i sits
   // in cell i and a load can write its cell directly.
   entry_type     ring_entry [TABLE_ENTRIES];
   entry_type     load_entry;
   entry_type     tail_entry;
   ring_ctrl_type ring_ctrl;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      entry_type prev_entry;
      logic      cell_load;

      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign prev_entry = tail_entry;
      end else begin : g_mid
         assign prev_entry = ring_entry[i+1];
      end

      // load targets the cell whose index matches the slot
      assign cell_load = ring_ctrl.load && (32'(ring_ctrl.load_slot) == i);

      pfts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (ring_ctrl.shift),
         .load       (cell_load),
         .load_entry (load_entry),
         .prev_entry (prev_entry),
         .entry      (ring_entry[i])
      );
   end

   // Sequencer: accepts words while idle, runs the scan, holds one found
   // frame back so the final frame of a run can carry last_of_run, and
   // drives the rsp output register.
   pfts_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_entry (ring_entry[0]),
      .load_entry (load_entry),
      .tail_entry (tail_entry),
      .ring_ctrl  (ring_ctrl)
   );

   // a cell is written only by an accepted load word
   `PFTS_ASSERT_IMP(a_load_on_accept, clock, reset, ring_ctrl.load, req_valid && req_ready)
   // the ring turns only during a scan, never while words are taken
   `PFTS_ASSERT_IMP(a_shift_not_idle, clock, reset, ring_ctrl.shift, !req_ready)
   // a waiting rsp word stays valid and unchanged until taken
   `PFTS_ASSERT_NXT(a_rsp_hold, clock, reset,
                    rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule
`default_nettype wire
